// ----- hw/rtl/srtn_pkg.sv -----
package srtn_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int TIME_BITS   = 16;
    localparam int ID_BITS     = 8;

    // Table index and queue rank both span 0 .. QUEUE_DEPTH-1.
    localparam int IDX_BITS    = $clog2(QUEUE_DEPTH);
    // Fill count spans 0 .. QUEUE_DEPTH.
    localparam int CNT_BITS    = $clog2(QUEUE_DEPTH + 1);
    localparam int ENTRY_BITS  = ID_BITS + TIME_BITS;

    localparam logic MODE_TICK   = 1'b0;
    localparam logic MODE_ARRIVE = 1'b1;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_SCAN = 4'b0010,
        S_FIN  = 4'b0100,
        S_UPD  = 4'b1000
    } t_state;

endpackage

// ----- hw/rtl/srtn_scheduler.sv -----
// Channel   Direction  Handshake                Payload
// input     in         i_in_valid / o_in_stall  i_mode, i_proc_id, i_time_needed
// output    out        o_out_valid / i_out_stall o_running_valid, o_running_id,
//                                               o_running_time_left, o_arrival_dropped
//
// Every word passes through the accept state, one sweep of the ready table
// memory at one entry per cycle, a last read and an update state. The single
// read port of the table memory sets this sequence.
// Reset (i_rst_n low at a clock edge) empties the table and stops the running
// process at once; the table memory itself is not cleared.
// A result waits in the output register while the next word is accepted and
// scanned; the update cycle holds only while that register is still full and i_out_stall is high.
module srtn_scheduler
    import srtn_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,

    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic                 i_mode,
    input  logic [ID_BITS-1:0]   i_proc_id,
    input  logic [TIME_BITS-1:0] i_time_needed,

    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic                 o_running_valid,
    output logic [ID_BITS-1:0]   o_running_id,
    output logic [TIME_BITS-1:0] o_running_time_left,
    output logic                 o_arrival_dropped
);

    // Control state.
    t_state                 r_state;
    logic                   r_run_vld;
    logic [QUEUE_DEPTH-1:0] r_rdy_vld;
    logic [CNT_BITS-1:0]    r_count;
    logic                   r_out_vld;
    logic                   r_rd_act;
    logic                   r_best_found;
    logic                   r_free_found;

    // Running process and queue ranks. The ranks sit in flip-flops so that a
    // pop can close the gap it leaves in a single update.
    logic [ID_BITS-1:0]     r_run_id;
    logic [TIME_BITS-1:0]   r_run_time;
    logic [IDX_BITS-1:0]    r_order [QUEUE_DEPTH];

    // Latched input word.
    logic                   r_mode;
    logic [ID_BITS-1:0]     r_aid;
    logic [TIME_BITS-1:0]   r_at;

    // Sweep state.
    logic [IDX_BITS-1:0]    r_idx;
    logic [IDX_BITS-1:0]    r_rd_idx;
    logic                   r_rd_vbit;
    logic [IDX_BITS-1:0]    r_rd_ord;
    logic [ENTRY_BITS-1:0]  r_rd_data;
    logic [IDX_BITS-1:0]    r_best_idx;
    logic [IDX_BITS-1:0]    r_best_ord;
    logic [ID_BITS-1:0]     r_best_id;
    logic [TIME_BITS-1:0]   r_best_time;
    logic [IDX_BITS-1:0]    r_free_idx;

    // Output register payload.
    logic                   r_out_run_vld;
    logic [ID_BITS-1:0]     r_out_id;
    logic [TIME_BITS-1:0]   r_out_time;
    logic                   r_out_drop;

    // Ready table memory: {id, time} per entry.
    logic [ENTRY_BITS-1:0]  mem [QUEUE_DEPTH];

    logic                   in_acc;
    logic                   out_free;
    logic                   upd_go;
    logic [ID_BITS-1:0]     rd_id;
    logic [TIME_BITS-1:0]   rd_time;
    logic                   take_rd;

    logic                   n_run_vld;
    logic [ID_BITS-1:0]     n_run_id;
    logic [TIME_BITS-1:0]   n_run_time;
    logic                   n_drop;
    logic                   n_push;
    logic [ID_BITS-1:0]     n_push_id;
    logic [TIME_BITS-1:0]   n_push_time;
    logic                   n_pop;

    assign in_acc   = i_in_valid && (r_state == S_IDLE);
    assign out_free = !r_out_vld || !i_out_stall;
    assign upd_go   = (r_state == S_UPD) && out_free;

    assign rd_id    = r_rd_data[ENTRY_BITS-1:TIME_BITS];
    assign rd_time  = r_rd_data[TIME_BITS-1:0];

    // The entry just read beats the best so far on a strictly smaller time,
    // or on an equal time with an older rank.
    assign take_rd = r_rd_act && r_rd_vbit &&
                     (!r_best_found || (rd_time < r_best_time) ||
                      ((rd_time == r_best_time) && (r_rd_ord < r_best_ord)));

    // Outcome of one word, evaluated in the update cycle.
    always_comb begin
        n_run_vld   = r_run_vld;
        n_run_id    = r_run_id;
        n_run_time  = r_run_time;
        n_drop      = 1'b0;
        n_push      = 1'b0;
        n_push_id   = r_aid;
        n_push_time = r_at;
        n_pop       = 1'b0;
        case (r_mode)
            MODE_TICK: begin
                if (r_run_vld && (r_run_time != '0)) begin
                    n_run_time = r_run_time - 1'b1;
                end else if (r_best_found) begin
                    // Take the shortest entry and count it down, saturating.
                    n_pop      = 1'b1;
                    n_run_vld  = 1'b1;
                    n_run_id   = r_best_id;
                    n_run_time = (r_best_time != '0) ? r_best_time - 1'b1 : r_best_time;
                end else begin
                    n_run_vld  = 1'b0;
                    n_run_id   = '0;
                    n_run_time = '0;
                end
            end
            MODE_ARRIVE: begin
                if (r_run_vld && (r_at < r_run_time)) begin
                    // Preemption: the displaced process goes back to the table, if it has room.
                    if (r_free_found) begin
                        n_push      = 1'b1;
                        n_push_id   = r_run_id;
                        n_push_time = r_run_time;
                        n_run_id    = r_aid;
                        n_run_time  = r_at;
                    end else begin
                        n_drop = 1'b1;
                    end
                end else if (r_free_found) begin
                    n_push = 1'b1;
                end else begin
                    n_drop = 1'b1;
                end
            end
            default: begin
                n_drop = 1'b0;
            end
        endcase
    end

    // Table memory: one read per cycle during the sweep, one write at update.
    always_ff @(posedge i_clk) begin
        if (upd_go && n_push) begin
            mem[r_free_idx] <= {n_push_id, n_push_time};
        end
        r_rd_data <= mem[r_idx];
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_run_vld    <= 1'b0;
            r_run_id     <= '0;
            r_run_time   <= '0;
            r_rdy_vld    <= '0;
            r_count      <= '0;
            r_out_vld    <= 1'b0;
            r_rd_act     <= 1'b0;
            r_best_found <= 1'b0;
            r_free_found <= 1'b0;
        end else begin
            // The output register empties when its word is taken, unless the
            // update cycle refills it at the same edge.
            if (r_out_vld && !i_out_stall && !upd_go) begin
                r_out_vld <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_state      <= S_SCAN;
                        r_rd_act     <= 1'b0;
                        r_best_found <= 1'b0;
                        r_free_found <= 1'b0;
                    end
                end
                S_SCAN: begin
                    r_rd_act <= 1'b1;
                    if (take_rd) begin
                        r_best_found <= 1'b1;
                    end
                    if (r_rd_act && !r_rd_vbit) begin
                        r_free_found <= 1'b1;
                    end
                    if (r_idx == IDX_BITS'(QUEUE_DEPTH - 1)) begin
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    r_rd_act <= 1'b0;
                    if (take_rd) begin
                        r_best_found <= 1'b1;
                    end
                    if (r_rd_act && !r_rd_vbit) begin
                        r_free_found <= 1'b1;
                    end
                    r_state <= S_UPD;
                end
                S_UPD: begin
                    if (out_free) begin
                        r_state    <= S_IDLE;
                        r_out_vld  <= 1'b1;
                        r_run_vld  <= n_run_vld;
                        r_run_id   <= n_run_id;
                        r_run_time <= n_run_time;
                        if (n_push) begin
                            r_rdy_vld[r_free_idx] <= 1'b1;
                            r_count               <= r_count + 1'b1;
                        end
                        if (n_pop) begin
                            r_rdy_vld[r_best_idx] <= 1'b0;
                            r_count               <= r_count - 1'b1;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_mode <= i_mode;
            r_aid  <= i_proc_id;
            r_at   <= i_time_needed;
            r_idx  <= '0;
        end else if (r_state == S_SCAN) begin
            r_idx <= r_idx + 1'b1;
        end

        r_rd_idx  <= r_idx;
        r_rd_vbit <= r_rdy_vld[r_idx];
        r_rd_ord  <= r_order[r_idx];

        if (take_rd) begin
            r_best_idx  <= r_rd_idx;
            r_best_ord  <= r_rd_ord;
            r_best_id   <= rd_id;
            r_best_time <= rd_time;
        end
        if (r_rd_act && !r_rd_vbit && !r_free_found) begin
            r_free_idx <= r_rd_idx;
        end

        if (upd_go) begin
            r_out_run_vld <= n_run_vld;
            r_out_id      <= n_run_vld ? n_run_id : '0;
            r_out_time    <= n_run_vld ? n_run_time : '0;
            r_out_drop    <= n_drop;
        end

        // Ranks: a push joins at the back, a pop moves younger entries up.
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            if (upd_go && n_push && (r_free_idx == IDX_BITS'(i))) begin
                r_order[i] <= r_count[IDX_BITS-1:0];
            end else if (upd_go && n_pop && r_rdy_vld[i] && (r_order[i] > r_best_ord)) begin
                r_order[i] <= r_order[i] - 1'b1;
            end
        end
    end

    assign o_in_stall          = (r_state != S_IDLE);
    assign o_out_valid         = r_out_vld;
    assign o_running_valid     = r_out_run_vld;
    assign o_running_id        = r_out_id;
    assign o_running_time_left = r_out_time;
    assign o_arrival_dropped   = r_out_drop;

    // The fill count tracks the table's valid bits.
    a_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count == CNT_BITS'($countones(r_rdy_vld)))
        else $error("fill count differs from valid bits");

    // An idle scheduler holds no stale process.
    a_idle_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_run_vld |-> (r_run_id == '0) && (r_run_time == '0))
        else $error("idle scheduler holds a process");

    // A drop only happens when the sweep found the table full.
    a_drop_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (upd_go && n_drop) |-> (r_count == CNT_BITS'(QUEUE_DEPTH)))
        else $error("arrival dropped with room in the table");

    // Each update cycle that proceeds leaves a word in the output register.
    a_out_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        upd_go |=> r_out_vld)
        else $error("update did not load the output register");

endmodule
